// File: hw/rtl/i8080_enc_pkg.sv
// ----------------------------------------------------------------------------
// i8080_enc_pkg
// Shared types and constants of the 8080 instruction encoder: operand forms,
// the request beat, and the encoded byte run.
// ----------------------------------------------------------------------------
package i8080_enc_pkg;

  // Operand form of one instruction request.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_REG_LO = 4'd1,
    OP_REG_HI = 4'd2,
    OP_PAIR   = 4'd3,
    OP_IMM8   = 4'd4,
    OP_MVI    = 4'd5,
    OP_LXI    = 4'd6,
    OP_ADDR   = 4'd7,
    OP_MOV    = 4'd8,
    OP_LDAX   = 4'd9
  } op_e;

  // A MOV that lands on this code would be HLT.
  localparam logic [7:0] HltOpcode = 8'h76;

  // Most bytes one instruction can produce.
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // One instruction request as it is held inside the block.
  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  base_opcode;
    logic [7:0]  first_register;
    logic [7:0]  second_register;
    logic [15:0] operand_value;
  } req_t;

  // The encoded run: its bytes, index of the final byte, and the error flag.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] code;
    logic [IdxW-1:0]          last_idx;
    logic                     reg_err;
  } run_t;

endpackage

// File: hw/rtl/i8080_enc_req_if.sv
// ----------------------------------------------------------------------------
// i8080_enc_req_if
// Valid/ready channel that carries one instruction request per beat.
// ----------------------------------------------------------------------------
interface i8080_enc_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [7:0]  base_opcode;
  logic [7:0]  first_register;
  logic [7:0]  second_register;
  logic [15:0] operand_value;

  modport source (
    output valid, op, base_opcode, first_register, second_register, operand_value,
    input  ready
  );

  modport sink (
    input  valid, op, base_opcode, first_register, second_register, operand_value,
    output ready
  );
endinterface

// File: hw/rtl/i8080_enc_byte_if.sv
// ----------------------------------------------------------------------------
// i8080_enc_byte_if
// Valid/ready channel that carries one machine code byte per beat.
// ----------------------------------------------------------------------------
interface i8080_enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;
  logic       register_error;

  modport source (
    output valid, code_byte, last_byte, register_error,
    input  ready
  );

  modport sink (
    input  valid, code_byte, last_byte, register_error,
    output ready
  );
endinterface

// File: hw/rtl/i8080_instruction_encoder.sv
// ----------------------------------------------------------------------------
// i8080_instruction_encoder
// Encodes 8080 instruction requests into runs of machine code bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one instruction request per beat: operand form, base opcode,
//   two raw register numbers and a 16-bit operand. byte_o gives the encoded
//   instruction as one to three byte beats; last_byte marks the final beat
//   and register_error is the same on every beat of one instruction.
//   16-bit operands leave low byte first.
// Path: a request accepted into the input register is encoded into the run
//   register, from which its first byte shows.
// Output: the single-byte output channel drains the run register; the next
//   instruction loads into it as the final byte leaves, while the request
//   after that can already wait in the input register.
// Stall: while byte_o.ready is low the current byte holds, one more request
//   waits in the input register, and req_i.ready drops once that is full.
// Reset: rst_ni clears both valid flags; no bytes are pending afterwards.
// ----------------------------------------------------------------------------
module i8080_instruction_encoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  i8080_enc_req_if.sink    req_i,
  i8080_enc_byte_if.source byte_o
);

  logic                             in_valid_q;
  i8080_enc_pkg::req_t              in_req_q;
  logic                             run_valid_q;
  i8080_enc_pkg::run_t              run_q;
  i8080_enc_pkg::run_t              run_d;
  logic [i8080_enc_pkg::IdxW-1:0]   idx_q;
  logic                             req_fire;
  logic                             out_fire;
  logic                             is_last;
  logic                             run_load;

  // Handshake bookkeeping.
  assign is_last  = (idx_q == run_q.last_idx);
  assign run_load = !run_valid_q || (byte_o.ready && is_last);
  assign req_i.ready = !in_valid_q || run_load;
  assign req_fire = req_i.valid && req_i.ready;
  assign out_fire = byte_o.valid && byte_o.ready;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= req_fire || (in_valid_q && !run_load);
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_req_q.op              <= req_i.op;
      in_req_q.base_opcode     <= req_i.base_opcode;
      in_req_q.first_register  <= req_i.first_register;
      in_req_q.second_register <= req_i.second_register;
      in_req_q.operand_value   <= req_i.operand_value;
    end
  end

  // Encoder between the input register and the run register.
  i8080_enc_core u_core (
    .req_i (in_req_q),
    .run_o (run_d)
  );

  // Run register control: reload when empty or when the final byte leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (run_load) begin
      run_valid_q <= in_valid_q;
      idx_q       <= '0;
    end else if (out_fire) begin
      idx_q <= idx_q + i8080_enc_pkg::IdxW'(1);
    end
  end

  // Run register payload.
  always_ff @(posedge clk_i) begin
    if (run_load && in_valid_q) begin
      run_q <= run_d;
    end
  end

  // Output beat: select the current byte of the run.
  assign byte_o.valid          = run_valid_q;
  assign byte_o.last_byte      = is_last;
  assign byte_o.register_error = run_q.reg_err;

  always_comb begin
    unique case (idx_q)
      2'd0:    byte_o.code_byte = run_q.code[0];
      2'd1:    byte_o.code_byte = run_q.code[1];
      default: byte_o.code_byte = run_q.code[2];
    endcase
  end

endmodule

// File: hw/rtl/i8080_enc_core.sv
// ----------------------------------------------------------------------------
// i8080_enc_core
// Combinational encoder: turns one request into its run of one to three
// bytes, places register numbers into the opcode and checks them.
// ----------------------------------------------------------------------------
module i8080_enc_core (
  input  i8080_enc_pkg::req_t req_i,
  output i8080_enc_pkg::run_t run_o
);

  logic [7:0] opc;
  logic [7:0] r1;
  logic [7:0] r2;
  logic [7:0] lo_byte;
  logic [7:0] hi_byte;
  logic [7:0] r1_low;
  logic [7:0] r1_high;
  logic [7:0] mov_code;
  logic       r1_range_err;
  logic       r2_range_err;
  logic       r1_odd;
  logic       r1_not_bd;

  assign opc     = req_i.base_opcode;
  assign r1      = req_i.first_register;
  assign r2      = req_i.second_register;
  assign lo_byte = req_i.operand_value[7:0];
  assign hi_byte = req_i.operand_value[15:8];

  // Register placement wraps to 8 bits, so only the low bits of a high
  // placement survive the shift.
  assign r1_low  = r1;
  assign r1_high = {r1[4:0], 3'b000};

  // Register checks.
  assign r1_range_err = |r1[7:3];
  assign r2_range_err = |r2[7:3];
  assign r1_odd       = r1[0];
  assign r1_not_bd    = |{r1[7:2], r1[0]};

  // MOV puts the destination high and the source low.
  assign mov_code = opc + r1_high + r2;

  // Byte run per operand form.
  always_comb begin
    run_o.code     = '0;
    run_o.last_idx = '0;
    run_o.reg_err  = 1'b0;
    unique case (i8080_enc_pkg::op_e'(req_i.op))
      i8080_enc_pkg::OP_REG_LO: begin
        run_o.code[0] = opc + r1_low;
        run_o.reg_err = r1_range_err;
      end
      i8080_enc_pkg::OP_REG_HI: begin
        run_o.code[0] = opc + r1_high;
        run_o.reg_err = r1_range_err;
      end
      i8080_enc_pkg::OP_PAIR: begin
        run_o.code[0] = opc + r1_high;
        run_o.reg_err = r1_range_err | r1_odd;
      end
      i8080_enc_pkg::OP_IMM8: begin
        run_o.code[0]  = opc;
        run_o.code[1]  = lo_byte;
        run_o.last_idx = i8080_enc_pkg::IdxW'(1);
      end
      i8080_enc_pkg::OP_MVI: begin
        run_o.code[0]  = opc + r1_high;
        run_o.code[1]  = lo_byte;
        run_o.last_idx = i8080_enc_pkg::IdxW'(1);
        run_o.reg_err  = r1_range_err;
      end
      i8080_enc_pkg::OP_LXI: begin
        run_o.code[0]  = opc + r1_high;
        run_o.code[1]  = lo_byte;
        run_o.code[2]  = hi_byte;
        run_o.last_idx = i8080_enc_pkg::IdxW'(2);
        run_o.reg_err  = r1_range_err | r1_odd;
      end
      i8080_enc_pkg::OP_ADDR: begin
        run_o.code[0]  = opc;
        run_o.code[1]  = lo_byte;
        run_o.code[2]  = hi_byte;
        run_o.last_idx = i8080_enc_pkg::IdxW'(2);
      end
      i8080_enc_pkg::OP_MOV: begin
        run_o.code[0] = mov_code;
        run_o.reg_err = r1_range_err | r2_range_err
                        | (mov_code == i8080_enc_pkg::HltOpcode);
      end
      i8080_enc_pkg::OP_LDAX: begin
        run_o.code[0] = opc + r1_high;
        run_o.reg_err = r1_range_err | r1_not_bd;
      end
      default: begin
        // Form none and unused form codes: the opcode alone.
        run_o.code[0] = opc;
      end
    endcase
  end

endmodule
